### hdl/aat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aat_pkg;

  localparam int COEF_W    = 16;
  localparam int FIELD_W   = 16;
  localparam int FRAC_BITS = 14;
  localparam int ROW_W     = 64;
  localparam int NUM_AXES  = 3;

  localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h4000_0000_0000_0000;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_4000_0000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_0000_4000_0000;

  typedef enum logic [1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] lo_x;
    logic signed [FIELD_W-1:0] lo_y;
    logic signed [FIELD_W-1:0] lo_z;
    logic signed [FIELD_W-1:0] hi_x;
    logic signed [FIELD_W-1:0] hi_y;
    logic signed [FIELD_W-1:0] hi_z;
  } box_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_lo_x;
    logic signed [FIELD_W-1:0] out_lo_y;
    logic signed [FIELD_W-1:0] out_lo_z;
    logic signed [FIELD_W-1:0] out_hi_x;
    logic signed [FIELD_W-1:0] out_hi_y;
    logic signed [FIELD_W-1:0] out_hi_z;
    logic                      clipped;
  } box_out_t;

endpackage

`default_nettype wire

### hdl/aat_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module aat_lane #(
  parameter int COORD_BITS = 16,
  parameter int SUM_W      = 34
) (
  input  wire logic                         clk,
  input  wire logic [aat_pkg::ROW_W-1:0]    row,
  input  wire logic signed [COORD_BITS-1:0] lo [3],
  input  wire logic signed [COORD_BITS-1:0] hi [3],
  output      logic signed [SUM_W-1:0]      sum_lo,
  output      logic signed [SUM_W-1:0]      sum_hi
);
  import aat_pkg::*;

  localparam int PW = COEF_W + COORD_BITS;

  logic signed [COEF_W-1:0] coef [3];
  logic signed [PW-1:0]     p_lo [3];
  logic signed [PW-1:0]     p_hi [3];
  logic signed [COEF_W-1:0] t_q;
  logic signed [SUM_W-1:0]  mn [3];
  logic signed [SUM_W-1:0]  mx [3];
  logic signed [SUM_W-1:0]  t_ext;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coef[i] = signed'(row[ROW_W-1-COEF_W*i -: COEF_W]);
    end
  end

  // products of each coefficient with both box edges
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_lo[i] <= PW'(coef[i] * lo[i]);
      p_hi[i] <= PW'(coef[i] * hi[i]);
    end
    t_q <= signed'(row[COEF_W-1:0]);
  end

  // pick the smaller and larger term per input axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p_lo[i] < p_hi[i]) begin
        mn[i] = SUM_W'(p_lo[i]);
        mx[i] = SUM_W'(p_hi[i]);
      end else begin
        mn[i] = SUM_W'(p_hi[i]);
        mx[i] = SUM_W'(p_lo[i]);
      end
    end
    t_ext = {{(SUM_W-COEF_W-FRAC_BITS){t_q[COEF_W-1]}}, t_q, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    sum_lo <= mn[0] + mn[1] + mn[2] + t_ext;
    sum_hi <= mx[0] + mx[1] + mx[2] + t_ext;
  end

endmodule

`default_nettype wire

### hdl/aat_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module aat_merge #(
  parameter int COORD_BITS = 16,
  parameter int SUM_W      = 34
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    valid,
  input  wire logic signed [SUM_W-1:0] sum_lo [3],
  input  wire logic signed [SUM_W-1:0] sum_hi [3],
  output      logic                    done,
  output      aat_pkg::box_out_t       result
);
  import aat_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] MAX_V = (SUM_W'(1) <<< (COORD_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] MIN_V = -(SUM_W'(1) <<< (COORD_BITS - 1));

  logic signed [SUM_W-1:0] r_lo [3];
  logic signed [SUM_W-1:0] r_hi [3];
  logic [FIELD_W-1:0]      v_lo [3];
  logic [FIELD_W-1:0]      v_hi [3];
  logic                    sat;

  always_comb begin
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r_lo[i] = (sum_lo[i] + HALF_LSB) >>> FRAC_BITS;
      r_hi[i] = (sum_hi[i] + HALF_LSB) >>> FRAC_BITS;
      if (r_lo[i] > MAX_V) begin
        v_lo[i] = FIELD_W'(MAX_V[COORD_BITS-1:0]);
        sat = 1'b1;
      end else if (r_lo[i] < MIN_V) begin
        v_lo[i] = FIELD_W'(MIN_V[COORD_BITS-1:0]);
        sat = 1'b1;
      end else begin
        v_lo[i] = FIELD_W'(r_lo[i][COORD_BITS-1:0]);
      end
      if (r_hi[i] > MAX_V) begin
        v_hi[i] = FIELD_W'(MAX_V[COORD_BITS-1:0]);
        sat = 1'b1;
      end else if (r_hi[i] < MIN_V) begin
        v_hi[i] = FIELD_W'(MIN_V[COORD_BITS-1:0]);
        sat = 1'b1;
      end else begin
        v_hi[i] = FIELD_W'(r_hi[i][COORD_BITS-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    result.out_lo_x <= v_lo[0];
    result.out_lo_y <= v_lo[1];
    result.out_lo_z <= v_lo[2];
    result.out_hi_x <= v_hi[0];
    result.out_hi_y <= v_hi[1];
    result.out_hi_z <= v_hi[2];
    result.clipped  <= sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

endmodule

`default_nettype wire

### hdl/aabb_affine_transform.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounds an axis-aligned box after an affine map. A box word is taken on any
// cycle with start high; busy never rises, so one box can enter every cycle.
// Its result appears on result with done high after these registers in turn:
// input register, product stage, sum stage, then the round/saturate output
// register. The receiver cannot stall, so done is a one-cycle strobe. Three
// axis lanes of six 16 x COORD_BITS multipliers each set the per-box cost; the
// extreme corners are found by choosing the smaller and larger product per
// term, and rounding then saturation keep that order, so the eight corners
// need not be formed. Write row registers only with no box in flight.
module aabb_affine_transform #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire aat_pkg::box_in_t               box,
  output      logic                           done,
  output      aat_pkg::box_out_t              result,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [aat_pkg::ROW_W-1:0]      cfg_data
);
  import aat_pkg::*;

  localparam int SUM_W = (COORD_BITS + 18 > 32) ? COORD_BITS + 18 : 32;

  logic [ROW_W-1:0]            rows [NUM_AXES];
  logic signed [COORD_BITS-1:0] lo [3];
  logic signed [COORD_BITS-1:0] hi [3];
  logic                        v0;
  logic                        v1;
  logic                        v2;
  logic signed [SUM_W-1:0]     sum_lo [NUM_AXES];
  logic signed [SUM_W-1:0]     sum_hi [NUM_AXES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= ROW_X_RESET;
      rows[1] <= ROW_Y_RESET;
      rows[2] <= ROW_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_X: rows[0] <= cfg_data;
        REG_ROW_Y: rows[1] <= cfg_data;
        REG_ROW_Z: rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the box, keeping the low coordinate bits
  always_ff @(posedge clk) begin
    lo[0] <= signed'(box.lo_x[COORD_BITS-1:0]);
    lo[1] <= signed'(box.lo_y[COORD_BITS-1:0]);
    lo[2] <= signed'(box.lo_z[COORD_BITS-1:0]);
    hi[0] <= signed'(box.hi_x[COORD_BITS-1:0]);
    hi[1] <= signed'(box.hi_y[COORD_BITS-1:0]);
    hi[2] <= signed'(box.hi_z[COORD_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0;
      v2 <= v1;
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    aat_lane #(
      .COORD_BITS(COORD_BITS),
      .SUM_W     (SUM_W)
    ) u_lane (
      .clk   (clk),
      .row   (rows[g]),
      .lo    (lo),
      .hi    (hi),
      .sum_lo(sum_lo[g]),
      .sum_hi(sum_hi[g])
    );
  end

  aat_merge #(
    .COORD_BITS(COORD_BITS),
    .SUM_W     (SUM_W)
  ) u_merge (
    .clk   (clk),
    .rst   (rst),
    .valid (v2),
    .sum_lo(sum_lo),
    .sum_hi(sum_hi),
    .done  (done),
    .result(result)
  );

endmodule

`default_nettype wire

### tb/sv/aabb_affine_transform_tb.sv
`timescale 1ns / 1ps

module aabb_affine_transform_tb;
  import aat_pkg::*;

  localparam int LATENCY        = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_ROWS = 70;
  localparam longint COORD_MAX  = (longint'(1) <<< (FIELD_W - 1)) - 1;
  localparam longint COORD_MIN  = -(longint'(1) <<< (FIELD_W - 1));
  localparam longint HALF_LSB   = longint'(1) <<< (FRAC_BITS - 1);
  localparam logic [1:0] REG_NONE = 2'd3;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  box_in_t          box;
  logic             done;
  box_out_t         result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [ROW_W-1:0] cfg_data;

  logic [ROW_W-1:0] row_model [NUM_AXES];
  box_out_t         pending_bounds [$];
  int               errors = 0;
  int               idle_pct = 0;
  int               burst_left = 0;
  int               quiet_cycles = 0;
  string            field_name [6] = '{"out_lo_x", "out_lo_y", "out_lo_z",
                                       "out_hi_x", "out_hi_y", "out_hi_z"};

  aabb_affine_transform DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .box       (box),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic flag(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  // Exact Q.14 sum of one corner, rounded half up; saturation is left to the caller.
  function automatic longint map_coord(logic [ROW_W-1:0] row, longint x, longint y,
                                       longint z);
    longint a, b, c, t, acc;
    a = longint'($signed(row[63:48]));
    b = longint'($signed(row[47:32]));
    c = longint'($signed(row[31:16]));
    t = longint'($signed(row[15:0]));
    acc = a * x + b * y + c * z + (t <<< FRAC_BITS);
    return (acc + HALF_LSB) >>> FRAC_BITS;
  endfunction

  function automatic box_out_t bound_box(box_in_t b);
    box_out_t o;
    longint   x, y, z, v;
    longint   mn [NUM_AXES];
    longint   mx [NUM_AXES];
    logic     clip;
    clip = 1'b0;
    for (int k = 0; k < 8; k++) begin
      x = k[2] ? longint'(b.hi_x) : longint'(b.lo_x);
      y = k[0] ? longint'(b.hi_y) : longint'(b.lo_y);
      z = k[1] ? longint'(b.hi_z) : longint'(b.lo_z);
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        v = map_coord(row_model[ax], x, y, z);
        if (v > COORD_MAX) begin
          v = COORD_MAX;
          clip = 1'b1;
        end else if (v < COORD_MIN) begin
          v = COORD_MIN;
          clip = 1'b1;
        end
        if (k == 0 || v < mn[ax]) mn[ax] = v;
        if (k == 0 || v > mx[ax]) mx[ax] = v;
      end
    end
    o.out_lo_x = mn[0][FIELD_W-1:0];
    o.out_lo_y = mn[1][FIELD_W-1:0];
    o.out_lo_z = mn[2][FIELD_W-1:0];
    o.out_hi_x = mx[0][FIELD_W-1:0];
    o.out_hi_y = mx[1][FIELD_W-1:0];
    o.out_hi_z = mx[2][FIELD_W-1:0];
    o.clipped  = clip;
    return o;
  endfunction

  function automatic box_in_t make_box(longint lx, longint ly, longint lz,
                                       longint hx, longint hy, longint hz);
    box_in_t b;
    b.lo_x = lx[FIELD_W-1:0];
    b.lo_y = ly[FIELD_W-1:0];
    b.lo_z = lz[FIELD_W-1:0];
    b.hi_x = hx[FIELD_W-1:0];
    b.hi_y = hy[FIELD_W-1:0];
    b.hi_z = hz[FIELD_W-1:0];
    return b;
  endfunction

  function automatic box_in_t rand_box();
    box_in_t     b;
    logic [15:0] picks [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    logic [15:0] tmp;
    b = {$urandom, $urandom, $urandom};
    case ($urandom_range(3))
      0: begin
      end
      1: begin
        for (int i = 0; i < 6; i++)
          b[95-16*i -: 16] = 16'(int'($urandom_range(0, 400)) - 200);
      end
      2: begin
        for (int i = 0; i < 6; i++)
          b[95-16*i -: 16] = picks[$urandom_range(4)];
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          if ($signed(b[95-16*i -: 16]) > $signed(b[47-16*i -: 16])) begin
            tmp = b[95-16*i -: 16];
            b[95-16*i -: 16] = b[47-16*i -: 16];
            b[47-16*i -: 16] = tmp;
          end
        end
      end
    endcase
    return b;
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] r;
    logic [15:0]      picks [6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                    16'h4000, 16'hC000};
    int               pos;
    r = {$urandom, $urandom};
    case ($urandom_range(3))
      0: begin
      end
      1: begin
        for (int i = 0; i < 3; i++)
          r[63-16*i -: 16] = 16'(int'($urandom_range(0, 32768)) - 16384);
        r[15:0] = 16'(int'($urandom_range(0, 2000)) - 1000);
      end
      2: begin
        pos = $urandom_range(2);
        r[63:16] = '0;
        r[63-16*pos -: 16] = $urandom_range(1) ? 16'h4000 : 16'hC000;
      end
      default: begin
        for (int i = 0; i < 4; i++)
          r[63-16*i -: 16] = picks[$urandom_range(5)];
      end
    endcase
    return r;
  endfunction

  task automatic hold_start(input int n);
    start <= 1'b0;
    repeat (n) begin
      box <= {$urandom, $urandom, $urandom};
      @(posedge clk);
    end
  endtask

  task automatic send_box(input box_in_t b);
    if (burst_left > 0)
      burst_left--;
    else if ($urandom_range(99) < 4)
      burst_left = $urandom_range(10, 30);
    else if ($urandom_range(99) < idle_pct)
      hold_start($urandom_range(1, 5));
    start <= 1'b1;
    box   <= b;
    do @(posedge clk); while (busy);
    pending_bounds.push_back(bound_box(b));
  endtask

  // Leave cfg_valid high; the caller drops it after its last word.
  task automatic write_reg(input logic [1:0] idx, input logic [ROW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (cfg_reg_t'(idx))
      REG_ROW_X, REG_ROW_Y, REG_ROW_Z: row_model[idx] = data;
      default: ;
    endcase
  endtask

  task automatic set_rows(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                          input logic [ROW_W-1:0] rz);
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic test_reset_identity();
    send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(-1, -1, -1, -1, -1, -1));
    send_box(make_box(500, -20, 7, -300, -900, 3));
    send_box(make_box(COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, -1));
    wait_idle();
  endtask

  // Half steps must round toward plus infinity.
  task automatic test_rounding();
    set_rows(64'h2000_0000_0000_0000, 64'h0000_1555_0000_0000, 64'h0000_0000_6000_FFFB);
    send_box(make_box(-1, -1, -1, 1, 1, 1));
    send_box(make_box(-3, -2, -3, 3, 2, 3));
    send_box(make_box(-5, 4, 1, -5, 5, 1));
    send_box(make_box(7, -7, -7, -7, 7, 7));
    wait_idle();
  endtask

  task automatic test_saturation();
    set_rows(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
    send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(make_box(1, 1, 1, 2, 2, 2));
    wait_idle();
    set_rows(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
    send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    wait_idle();
    set_rows(64'h0000_0000_0000_7FFF, 64'h0000_0000_0000_8000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
    wait_idle();
  endtask

  // Writes past the last row register must leave all rows untouched.
  task automatic test_ignored_index();
    write_reg(REG_ROW_X, 64'hC000_0000_0000_0010);
    write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_NONE, 64'h0000_0000_0000_0000);
    write_reg(REG_ROW_Y, 64'h0000_C000_0000_FFF0);
    write_reg(REG_ROW_Z, 64'h0000_0000_4000_0000);
    cfg_valid <= 1'b0;
    send_box(make_box(-100, 200, -300, 100, -200, 300));
    send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    wait_idle();
  endtask

  task automatic test_random_streams();
    int pct [3] = '{0, 79, 23};
    for (int p = 0; p < 3; p++) begin
      idle_pct = pct[p];
      burst_left = 0;
      for (int s = 0; s < 4; s++) begin
        if (s == 3) begin
          write_reg(REG_NONE, {$urandom, $urandom});
        end
        set_rows(rand_row(), rand_row(), rand_row());
        repeat (ITEMS_PER_ROWS) send_box(rand_box());
        wait_idle();
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    box_out_t want;
    if (!rst && done) begin
      if (pending_bounds.size() == 0) begin
        flag($sformatf("unexpected result word %h", result));
      end else begin
        want = pending_bounds.pop_front();
        for (int i = 0; i < 6; i++)
          if (result[96-16*i -: 16] !== want[96-16*i -: 16])
            flag($sformatf("%s got %h exp %h", field_name[i],
                           result[96-16*i -: 16], want[96-16*i -: 16]));
        if (result.clipped !== want.clipped)
          flag($sformatf("clipped got %b exp %b", result.clipped, want.clipped));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    box       = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    row_model[0] = ROW_X_RESET;
    row_model[1] = ROW_Y_RESET;
    row_model[2] = ROW_Z_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_identity();
    test_rounding();
    test_saturation();
    test_ignored_index();
    test_random_streams();
    wait_idle();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
hdl/aat_pkg.sv
hdl/aat_lane.sv
hdl/aat_merge.sv
hdl/aabb_affine_transform.sv
tb/sv/aabb_affine_transform_tb.sv
